@@ rtl/lkvt_pkg.sv @@
// Shared types and codes for the linear key-value table.
`default_nettype none

package lkvt_pkg;

   // Operation codes carried on req_mode
   localparam logic [2:0] MODE_LOOKUP = 3'd0;
   localparam logic [2:0] MODE_FETCH  = 3'd1;
   localparam logic [2:0] MODE_WRITE  = 3'd2;
   localparam logic [2:0] MODE_DELETE = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam int DataW  = 32;
   localparam int CountW = 7;

   // Partial search result handed from cell to cell along the row
   typedef struct packed {
      logic             hit;
      logic [DataW-1:0] value;
      logic [DataW-1:0] last_key;
      logic [DataW-1:0] last_value;
   } lkvt_wave_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic [DataW-1:0] key;
      logic             write_hit;
      logic             append;
      logic [DataW-1:0] data_key;
      logic [DataW-1:0] data_value;
   } lkvt_cmd_type;

endpackage

`default_nettype wire

@@ rtl/lkvt_cell.sv @@
// One table entry: holds a key and value, matches the query and passes the search on.
`default_nettype none

module lkvt_cell #(
   parameter int CAPACITY = 64,
   parameter int INDEX    = 0
) (
   input  wire logic                             clock,
   input  wire lkvt_pkg::lkvt_cmd_type           cmd,
   input  wire logic [$clog2(CAPACITY+1)-1:0]    count,
   input  wire lkvt_pkg::lkvt_wave_type          prev_wave,
   output lkvt_pkg::lkvt_wave_type               next_wave
);

   localparam int CntW = $clog2(CAPACITY + 1);

   logic [lkvt_pkg::DataW-1:0] key_ff;
   logic [lkvt_pkg::DataW-1:0] key_in;
   logic [lkvt_pkg::DataW-1:0] value_ff;
   logic [lkvt_pkg::DataW-1:0] value_in;
   lkvt_pkg::lkvt_wave_type    wave_ff;
   lkvt_pkg::lkvt_wave_type    wave_in;

   logic occupied;
   logic is_last;
   logic is_tail;
   logic hit;
   logic load;

   // Decode this slot's position against the entry count
   assign occupied = count > CntW'(INDEX);
   assign is_last  = count == CntW'(INDEX + 1);
   assign is_tail  = count == CntW'(INDEX);
   assign hit      = occupied && (key_ff == cmd.key);

   // Merge this entry into the passing search result
   always_comb begin
      wave_in = prev_wave;
      if (hit) begin
         wave_in.hit   = 1'b1;
         wave_in.value = value_ff;
      end
      if (is_last) begin
         wave_in.last_key   = key_ff;
         wave_in.last_value = value_ff;
      end
   end

   // Overwrite on a hit update, or take a fresh entry at the tail
   assign load     = (cmd.write_hit && hit) || (cmd.append && is_tail);
   assign key_in   = load ? cmd.data_key : key_ff;
   assign value_in = load ? cmd.data_value : value_ff;

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      wave_ff  <= wave_in;
   end

   assign next_wave = wave_ff;

endmodule

`default_nettype wire

@@ rtl/lkvt_ctrl.sv @@
// Sequencer for the table: holds the item, times the search and commits the result.
`default_nettype none

module lkvt_ctrl #(
   parameter int CAPACITY = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [2:0]                    req_mode,
   input  wire logic [lkvt_pkg::DataW-1:0]    req_key,
   input  wire logic [lkvt_pkg::DataW-1:0]    req_write_value,
   input  wire lkvt_pkg::lkvt_wave_type       result_wave,
   output lkvt_pkg::lkvt_cmd_type             cmd,
   output logic [$clog2(CAPACITY+1)-1:0]      count,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [lkvt_pkg::DataW-1:0]         rsp_value,
   output logic [1:0]                         rsp_status,
   output logic [lkvt_pkg::CountW-1:0]        rsp_count
);

   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int ExtW = CntW + lkvt_pkg::CountW;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]                 state_ff;
   logic [1:0]                 state_in;
   logic [CntW-1:0]            scan_ff;
   logic [CntW-1:0]            scan_in;
   logic [2:0]                 mode_ff;
   logic [2:0]                 mode_in;
   logic [lkvt_pkg::DataW-1:0] key_ff;
   logic [lkvt_pkg::DataW-1:0] key_in;
   logic [lkvt_pkg::DataW-1:0] wval_ff;
   logic [lkvt_pkg::DataW-1:0] wval_in;
   logic [CntW-1:0]            count_ff;
   logic [CntW-1:0]            count_in;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_found_ff;
   logic                       rsp_found_in;
   logic [lkvt_pkg::DataW-1:0] rsp_value_ff;
   logic [lkvt_pkg::DataW-1:0] rsp_value_in;
   logic [1:0]                 rsp_status_ff;
   logic [1:0]                 rsp_status_in;
   logic [lkvt_pkg::CountW-1:0] rsp_count_ff;
   logic [lkvt_pkg::CountW-1:0] rsp_count_in;

   logic                       accept;
   logic                       full;
   logic [ExtW-1:0]            count_ext;

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;
   assign full   = count_ff == CntW'(CAPACITY);

   // Sequence: latch the item, let the search cross every cell, then commit
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      mode_in  = mode_ff;
      key_in   = key_ff;
      wval_in  = wval_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               scan_in  = '0;
               mode_in  = req_mode;
               key_in   = req_key;
               wval_in  = req_write_value;
            end
         end
         ST_SCAN: begin
            if (scan_ff == CntW'(CAPACITY - 1)) begin
               state_in = ST_FINISH;
            end else begin
               scan_in = scan_ff + CntW'(1);
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Work out the table update and the result from the finished search
   always_comb begin
      cmd.key        = key_ff;
      cmd.write_hit  = 1'b0;
      cmd.append     = 1'b0;
      cmd.data_key   = key_ff;
      cmd.data_value = wval_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      rsp_found_in   = result_wave.hit;
      rsp_value_in   = '0;
      rsp_status_in  = lkvt_pkg::STATUS_OK;
      if (state_ff == ST_FINISH) begin
         rsp_valid_in = 1'b1;
         case (mode_ff)
            lkvt_pkg::MODE_FETCH, lkvt_pkg::MODE_WRITE: begin
               if (result_wave.hit) begin
                  if (mode_ff == lkvt_pkg::MODE_WRITE) begin
                     cmd.write_hit = 1'b1;
                     rsp_value_in  = wval_ff;
                  end else begin
                     rsp_value_in  = result_wave.value;
                  end
               end else if (full) begin
                  rsp_status_in = lkvt_pkg::STATUS_FULL;
               end else begin
                  cmd.append = 1'b1;
                  count_in   = count_ff + CntW'(1);
                  if (mode_ff == lkvt_pkg::MODE_WRITE) begin
                     rsp_value_in = wval_ff;
                  end else begin
                     cmd.data_value = '0;
                  end
               end
            end
            lkvt_pkg::MODE_DELETE: begin
               if (result_wave.hit) begin
                  cmd.write_hit  = 1'b1;
                  cmd.data_key   = result_wave.last_key;
                  cmd.data_value = result_wave.last_value;
                  count_in       = count_ff - CntW'(1);
               end else begin
                  rsp_status_in = lkvt_pkg::STATUS_MISSING;
               end
            end
            lkvt_pkg::MODE_CLEAR: begin
               count_in     = '0;
               rsp_found_in = 1'b0;
            end
            default: begin
               if (result_wave.hit) begin
                  rsp_value_in = result_wave.value;
               end
            end
         endcase
      end
   end

   // Report the count in the field's seven bits
   assign count_ext    = ExtW'(count_in);
   assign rsp_count_in = count_ext[lkvt_pkg::CountW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      wval_ff       <= wval_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign count      = count_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

`default_nettype wire

@@ rtl/linear_key_value_table_core.sv @@
// Top level of the linear key-value table: controller and row of entry cells.
`default_nettype none

// Key-value table of up to CAPACITY entries kept in a row of cells, one entry per
// cell. An item is taken when start is high and busy is low. The search for the
// key travels down the row one cell per clock, and busy stays high while it
// crosses the row and while the result is committed, so a new item is not taken
// until the last one is through. The result shows on the rsp_ ports for a single
// cycle, marked by rsp_valid, and must be taken then: there is no way to hold it
// off. rsp_count carries the low seven bits of the entry count.
module linear_key_value_table_core #(
   parameter int CAPACITY = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_mode,
   input  wire logic signed [31:0] req_key,
   input  wire logic signed [31:0] req_write_value,
   output logic                    rsp_valid,
   output logic                    rsp_found,
   output logic signed [31:0]      rsp_value,
   output logic [1:0]              rsp_status,
   output logic [6:0]              rsp_count
);

   localparam int CntW = $clog2(CAPACITY + 1);

   lkvt_pkg::lkvt_cmd_type             cmd;
   logic [CntW-1:0]                    count;
   lkvt_pkg::lkvt_wave_type            wave [CAPACITY+1];
   logic [lkvt_pkg::DataW-1:0]         value_out;

   // Launch an empty search result into the head of the row
   assign wave[0] = '0;

   lkvt_ctrl #(
      .CAPACITY(CAPACITY)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .req_write_value(req_write_value),
      .result_wave    (wave[CAPACITY]),
      .cmd            (cmd),
      .count          (count),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_value      (value_out),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   assign rsp_value = value_out;

   // Build the row of entry cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lkvt_cell #(
         .CAPACITY(CAPACITY),
         .INDEX   (i)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .count    (count),
         .prev_wave(wave[i]),
         .next_wave(wave[i+1])
      );
   end

endmodule

`default_nettype wire

@@ tb/linear_key_value_table_core_tb.sv @@
// Self-checking testbench for the linear key-value table core.
`timescale 1ns / 1ps

module linear_key_value_table_core_tb;
   import lkvt_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int RANDOM_ITEMS  = 650;
   localparam int POOL_SIZE     = 96;
   localparam int NUM_DIRECTED  = 25;
   localparam int REPORT_LIMIT  = 10;

   // Mode values outside the defined set; the block treats them as lookups
   localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
   localparam logic [2:0] MODE_SPARE_MID = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

   localparam logic [DataW-1:0] ZERO     = 32'h0000_0000;
   localparam logic [DataW-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [DataW-1:0] KEY_MIN  = 32'h8000_0000;
   localparam logic [DataW-1:0] KEY_MAX  = 32'h7FFF_FFFF;
   localparam logic [DataW-1:0] PAT_A    = 32'hAAAA_AAAA;
   localparam logic [DataW-1:0] PAT_5    = 32'h5555_5555;
   localparam logic [DataW-1:0] PAT_MID  = 32'h1234_5678;

   typedef struct packed {
      logic              found;
      logic [DataW-1:0]  value;
      logic [1:0]        status;
      logic [CountW-1:0] count;
   } table_reply_type;

   typedef struct packed {
      logic [2:0]       mode;
      logic [DataW-1:0] key;
      logic [DataW-1:0] write_value;
      logic             typed;
      table_reply_type  reply;
   } stim_row_type;

   typedef enum {PHASE_FILL, PHASE_MIX, PHASE_DRAIN} traffic_phase_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [2:0]              req_mode = MODE_LOOKUP;
   logic signed [DataW-1:0] req_key = '0;
   logic signed [DataW-1:0] req_write_value = '0;
   logic                    rsp_valid;
   logic                    rsp_found;
   logic signed [DataW-1:0] rsp_value;
   logic [1:0]              rsp_status;
   logic [CountW-1:0]       rsp_count;

   // Shadow copy of the table, updated as each item is accepted
   logic [DataW-1:0] shadow_keys [TABLE_DEPTH];
   logic [DataW-1:0] shadow_vals [TABLE_DEPTH];
   int               shadow_used = 0;

   table_reply_type  pending_replies [$];
   int               mismatch_count = 0;
   logic [DataW-1:0] key_pool [POOL_SIZE];
   logic [2:0]       spare_modes [3] = '{MODE_SPARE_LO, MODE_SPARE_MID, MODE_SPARE_HI};
   logic [DataW-1:0] extreme_words [4] = '{ZERO, ALL_ONES, KEY_MIN, KEY_MAX};

   // Directed items: extremes, every mode, misses, moves on delete, clear
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{MODE_LOOKUP,    ZERO,     ZERO,     1'b1, '{1'b0, ZERO,     STATUS_OK,      7'd0}},
      '{MODE_DELETE,    KEY_MAX,  ZERO,     1'b1, '{1'b0, ZERO,     STATUS_MISSING, 7'd0}},
      '{MODE_FETCH,     KEY_MIN,  ALL_ONES, 1'b1, '{1'b0, ZERO,     STATUS_OK,      7'd1}},
      '{MODE_WRITE,     KEY_MIN,  KEY_MAX,  1'b1, '{1'b1, KEY_MAX,  STATUS_OK,      7'd1}},
      '{MODE_WRITE,     ALL_ONES, KEY_MIN,  1'b1, '{1'b0, KEY_MIN,  STATUS_OK,      7'd2}},
      '{MODE_LOOKUP,    ALL_ONES, ZERO,     1'b1, '{1'b1, KEY_MIN,  STATUS_OK,      7'd2}},
      '{MODE_FETCH,     ALL_ONES, KEY_MAX,  1'b1, '{1'b1, KEY_MIN,  STATUS_OK,      7'd2}},
      '{MODE_WRITE,     ZERO,     ZERO,     1'b1, '{1'b0, ZERO,     STATUS_OK,      7'd3}},
      '{MODE_LOOKUP,    KEY_MAX,  ALL_ONES, 1'b1, '{1'b0, ZERO,     STATUS_OK,      7'd3}},
      '{MODE_SPARE_LO,  ALL_ONES, ZERO,     1'b1, '{1'b1, KEY_MIN,  STATUS_OK,      7'd3}},
      '{MODE_SPARE_MID, KEY_MIN,  ZERO,     1'b1, '{1'b1, KEY_MAX,  STATUS_OK,      7'd3}},
      '{MODE_SPARE_HI,  ZERO,     ALL_ONES, 1'b1, '{1'b1, ZERO,     STATUS_OK,      7'd3}},
      '{MODE_DELETE,    KEY_MIN,  ZERO,     1'b1, '{1'b1, ZERO,     STATUS_OK,      7'd2}},
      '{MODE_LOOKUP,    ZERO,     ZERO,     1'b1, '{1'b1, ZERO,     STATUS_OK,      7'd2}},
      '{MODE_LOOKUP,    ALL_ONES, ZERO,     1'b1, '{1'b1, KEY_MIN,  STATUS_OK,      7'd2}},
      '{MODE_DELETE,    KEY_MIN,  ZERO,     1'b1, '{1'b0, ZERO,     STATUS_MISSING, 7'd2}},
      '{MODE_WRITE,     ALL_ONES, KEY_MAX,  1'b1, '{1'b1, KEY_MAX,  STATUS_OK,      7'd2}},
      '{MODE_DELETE,    ALL_ONES, ZERO,     1'b1, '{1'b1, ZERO,     STATUS_OK,      7'd1}},
      '{MODE_CLEAR,     KEY_MAX,  ALL_ONES, 1'b1, '{1'b0, ZERO,     STATUS_OK,      7'd0}},
      '{MODE_LOOKUP,    ZERO,     ZERO,     1'b1, '{1'b0, ZERO,     STATUS_OK,      7'd0}},
      '{MODE_WRITE,     PAT_A,    PAT_5,    1'b0, '0},
      '{MODE_WRITE,     PAT_5,    PAT_A,    1'b0, '0},
      '{MODE_FETCH,     PAT_MID,  PAT_A,    1'b0, '0},
      '{MODE_DELETE,    PAT_A,    ZERO,     1'b0, '0},
      '{MODE_CLEAR,     PAT_5,    PAT_5,    1'b1, '{1'b0, ZERO,     STATUS_OK,      7'd0}}
   };

   linear_key_value_table_core #(
      .CAPACITY(TABLE_DEPTH)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .req_write_value(req_write_value),
      .rsp_valid      (rsp_valid),
      .rsp_found      (rsp_found),
      .rsp_value      (rsp_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one operation to the shadow table and return the reply it gives
   function automatic table_reply_type shadow_table_op(logic [2:0] mode,
                                                       logic [DataW-1:0] key,
                                                       logic [DataW-1:0] write_value);
      table_reply_type r;
      int slot;
      r = '0;
      slot = -1;
      for (int i = 0; i < shadow_used; i++) begin
         if (slot < 0 && shadow_keys[i] == key) slot = i;
      end
      r.found = (slot >= 0);
      r.status = STATUS_OK;
      case (mode)
         MODE_FETCH, MODE_WRITE: begin
            if (slot >= 0) begin
               if (mode == MODE_WRITE) shadow_vals[slot] = write_value;
               r.value = shadow_vals[slot];
            end else if (shadow_used >= TABLE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_keys[shadow_used] = key;
               shadow_vals[shadow_used] = (mode == MODE_WRITE) ? write_value : ZERO;
               r.value = shadow_vals[shadow_used];
               shadow_used++;
            end
         end
         MODE_DELETE: begin
            if (slot >= 0) begin
               shadow_keys[slot] = shadow_keys[shadow_used-1];
               shadow_vals[slot] = shadow_vals[shadow_used-1];
               shadow_used--;
            end else begin
               r.status = STATUS_MISSING;
            end
         end
         MODE_CLEAR: begin
            shadow_used = 0;
            r.found = 1'b0;
         end
         default: begin
            if (slot >= 0) r.value = shadow_vals[slot];
         end
      endcase
      r.count = shadow_used[CountW-1:0];
      return r;
   endfunction

   // Idle time before raising start: mostly none or short, a few long
   function automatic int pick_gap(bit steady);
      int roll;
      roll = $urandom_range(99);
      if (steady || roll < 45) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(20, 4);
      return $urandom_range(150, 30);
   endfunction

   // Offer one item, hold it until accepted, then record its expected reply
   task automatic send_item(input logic [2:0] mode, input logic [DataW-1:0] key,
                            input logic [DataW-1:0] write_value, input bit typed,
                            input table_reply_type typed_reply, input bit steady);
      int gap;
      table_reply_type predicted;
      table_reply_type expected;
      gap = pick_gap(steady);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_mode        <= mode;
      req_key         <= key;
      req_write_value <= write_value;
      do @(posedge clock); while (busy);
      predicted = shadow_table_op(mode, key, write_value);
      expected = typed ? typed_reply : predicted;
      pending_replies.insert(pending_replies.size(), expected);
   endtask

   task automatic note_mismatch(input string what, input table_reply_type want,
                                input table_reply_type seen);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s: expected found=%0b value=%h status=%0d count=%0d, ",
                  $time, what, want.found, want.value, want.status, want.count,
                  "got found=%0b value=%h status=%0d count=%0d",
                  seen.found, seen.value, seen.status, seen.count);
   endtask

   // Check each reply against the oldest outstanding item
   always @(posedge clock) begin
      table_reply_type seen, want;
      if (!reset && rsp_valid === 1'b1) begin
         seen = '{rsp_found, rsp_value, rsp_status, rsp_count};
         if (pending_replies.size() == 0) begin
            note_mismatch("reply with no item outstanding", '0, seen);
         end else begin
            want = pending_replies.pop_front();
            if (seen.found !== want.found || seen.value !== want.value ||
                seen.status !== want.status || seen.count !== want.count)
               note_mismatch("reply mismatch", want, seen);
         end
      end
   end

   // Stimulus: directed table, then phased random traffic
   initial begin
      int issued;
      int seg_len;
      int roll;
      bit steady;
      traffic_phase_type phase;
      logic [2:0] mode;
      logic [DataW-1:0] key;
      logic [DataW-1:0] write_value;

      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = (i < 4) ? extreme_words[i] : $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].mode, directed_rows[i].key, directed_rows[i].write_value,
                   directed_rows[i].typed, directed_rows[i].reply, 1'b0);

      // Open with a long fill so the table reaches capacity early
      issued = 0;
      phase = PHASE_FILL;
      seg_len = 100;
      while (issued < RANDOM_ITEMS) begin
         steady = ($urandom_range(4) == 0);
         for (int j = 0; j < seg_len && issued < RANDOM_ITEMS; j++) begin
            roll = $urandom_range(99);
            case (phase)
               PHASE_FILL: mode = (roll < 45) ? MODE_WRITE :
                                  (roll < 80) ? MODE_FETCH :
                                  (roll < 90) ? MODE_LOOKUP :
                                  (roll < 97) ? MODE_DELETE : spare_modes[$urandom_range(2)];
               PHASE_MIX:  mode = (roll < 22) ? MODE_LOOKUP :
                                  (roll < 40) ? MODE_FETCH :
                                  (roll < 58) ? MODE_WRITE :
                                  (roll < 82) ? MODE_DELETE :
                                  (roll < 86) ? MODE_CLEAR : spare_modes[$urandom_range(2)];
               default:    mode = (roll < 70) ? MODE_DELETE :
                                  (roll < 85) ? MODE_LOOKUP :
                                  (roll < 93) ? MODE_WRITE : MODE_FETCH;
            endcase

            // Mostly keys that are or may be held, some fully random
            roll = $urandom_range(99);
            if (roll < 15)
               key = $urandom;
            else if (shadow_used > 0 &&
                     (phase == PHASE_DRAIN || (phase == PHASE_MIX && roll < 55)))
               key = shadow_keys[$urandom_range(shadow_used-1)];
            else
               key = key_pool[$urandom_range(POOL_SIZE-1)];

            write_value = ($urandom_range(9) == 0) ? extreme_words[$urandom_range(3)] : $urandom;
            send_item(mode, key, write_value, 1'b0, '0, steady);
            issued++;
         end
         phase = traffic_phase_type'($urandom_range(2));
         case (phase)
            PHASE_FILL: seg_len = $urandom_range(100, 60);
            PHASE_MIX:  seg_len = $urandom_range(60, 20);
            default:    seg_len = $urandom_range(70, 30);
         endcase
      end
      start <= 1'b0;

      // Drain outstanding replies, then watch for strays
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #(10_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/lkvt_pkg.sv
rtl/lkvt_cell.sv
rtl/lkvt_ctrl.sv
rtl/linear_key_value_table_core.sv
tb/linear_key_value_table_core_tb.sv
